FILE: sv/assert_macros.svh
// assertion macros for the checker file euwv_chk
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/euwv_pkg.sv
// euwv_pkg: widths and constants for the encoder unwrap and window velocity block
// no dependencies
`default_nettype none

package euwv_pkg;

  localparam int ANGLE_W  = 12;
  localparam int ACC_W    = 32;
  localparam int SUM_W    = 16;
  localparam int SPEED_W  = 32;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = SUM_W + GAIN_W + 1;

  localparam int WINDOW_DEF = 16;
  localparam int WINDOW_MAX = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(200);

endpackage

`default_nettype wire

FILE: sv/euwv_ifs.sv
// euwv channel interfaces: sample input, result output, gain write
// depends on euwv_pkg
`default_nettype none

interface euwv_in_if;
  logic                            valid;
  logic                            ready;
  logic [euwv_pkg::ANGLE_W-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface euwv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [euwv_pkg::ANGLE_W-1:0] unwrapped_delta;
  logic signed [euwv_pkg::ACC_W-1:0]   angle_total;
  logic signed [euwv_pkg::SUM_W-1:0]   window_sum;
  logic signed [euwv_pkg::SPEED_W-1:0] speed;

  modport source (output valid, output unwrapped_delta, output angle_total,
                  output window_sum, output speed, input ready);
  modport sink   (input valid, input unwrapped_delta, input angle_total,
                  input window_sum, input speed, output ready);
endinterface

interface euwv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [euwv_pkg::GAIN_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/encoder_unwrap_window_velocity.sv
// encoder_unwrap_window_velocity: multi-turn unwrap of a 12-bit angle and
// moving-window speed; depends on euwv_pkg and euwv_ifs
//
// channel   dir  payload                                        width
// in_ch     in   sample                                         12
// out_ch    out  unwrapped_delta, angle_total, window_sum,      12/32/16/32
//                speed
// cfg_ch    in   rate_gain                                      16
//
// one item per cycle while out_ch is not stalled; each sample gives its result in the cycle after its transfer
// the single output register sets the latency; in_ch takes a new sample in the
// same cycle the held result is taken
// reset (rst_n low, synchronous) clears state, gain returns to 200, no clearing pass
// a stall on out_ch holds the result and holds in_ch
`default_nettype none

module encoder_unwrap_window_velocity #(
  parameter int WINDOW = euwv_pkg::WINDOW_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  euwv_in_if.sink     in_ch,
  euwv_out_if.source  out_ch,
  euwv_cfg_if.sink    cfg_ch
);
  import euwv_pkg::*;

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic [ANGLE_W-1:0]        last_r;
  logic                      started_r;
  logic [ACC_W-1:0]          acc_r;
  logic signed [ANGLE_W-1:0] ring_r [WINDOW];
  logic [PTR_W-1:0]          ptr_r;
  logic                      full_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [GAIN_W-1:0]         gain_r;

  logic                      out_valid_r;
  logic signed [ANGLE_W-1:0] out_delta_r;
  logic signed [ACC_W-1:0]   out_angle_r;
  logic signed [SUM_W-1:0]   out_sum_r;
  logic signed [SPEED_W-1:0] out_speed_r;

  logic                      in_xfer;
  logic [ANGLE_W-1:0]        base;
  logic signed [ANGLE_W-1:0] delta;
  logic signed [ANGLE_W-1:0] oldest;
  logic [ACC_W-1:0]          acc_nxt;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [PROD_W-1:0]  prod;
  logic [PTR_W-1:0]          ptr_nxt;

  assign in_ch.ready  = rst_n && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = rst_n;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    base    = started_r ? last_r : in_ch.sample;
    // difference mod one turn, read as signed, is the wrapped delta
    delta   = $signed(in_ch.sample - base);
    acc_nxt = acc_r + ACC_W'(delta);
    oldest  = full_r ? ring_r[ptr_r] : '0;
    sum_nxt = sum_r - SUM_W'(oldest) + SUM_W'(delta);
    prod    = PROD_W'(sum_nxt) * $signed({1'b0, gain_r});
    ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      started_r   <= 1'b0;
      acc_r       <= '0;
      ptr_r       <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        gain_r <= cfg_ch.data;
      end
      if (in_xfer) begin
        last_r    <= in_ch.sample;
        started_r <= 1'b1;
        acc_r     <= acc_nxt;
        ptr_r     <= ptr_nxt;
        full_r    <= full_r || (ptr_r == PTR_LAST);
        sum_r     <= sum_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ring entries and result payload need no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ring_r[ptr_r] <= delta;
      out_delta_r   <= delta;
      out_angle_r   <= $signed(acc_nxt);
      out_sum_r     <= sum_nxt;
      out_speed_r   <= prod[SPEED_W-1:0];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.unwrapped_delta = out_delta_r;
  assign out_ch.angle_total     = out_angle_r;
  assign out_ch.window_sum      = out_sum_r;
  assign out_ch.speed           = out_speed_r;

endmodule

`default_nettype wire

FILE: sv/euwv_chk.sv
// euwv_chk: port-level checks for encoder_unwrap_window_velocity, with its bind
// depends on euwv_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module euwv_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [euwv_pkg::ACC_W-1:0]   out_angle_total,
  input wire logic signed [euwv_pkg::SPEED_W-1:0] out_speed
);
  import euwv_pkg::*;

  // no result pending right after reset
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // a transfer on in_ch always leaves a result
  `ASSERT_ON(a_in_gives_out, in_valid && in_ready |=> out_valid, "sample lost")

  // a new sample never overwrites a result that is still held
  `ASSERT_ON(a_no_overwrite, in_valid && in_ready |-> !out_valid || out_ready, "result overwritten")

  // empty output register means the block takes a sample
  `ASSERT_ON(a_ready_when_empty, !out_valid |-> in_ready, "input stalled while empty")

  // stalled result holds
  `ASSERT_ON(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_angle_total) && $stable(out_speed), "stalled result changed")

endmodule

bind encoder_unwrap_window_velocity euwv_chk u_euwv_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_angle_total (out_ch.angle_total),
  .out_speed       (out_ch.speed)
);

`default_nettype wire
